/* design/ripple_uv_displacement_top_assert.svh */
// assertion macros for the ripple uv displacement block
// used by ripple_uv_displacement_top, expects clk and rst_n in scope
`ifndef RIPPLE_UV_DISPLACEMENT_TOP_ASSERT_SVH
`define RIPPLE_UV_DISPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define RUV_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RUV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ruv_pkg.sv */
// constants and types for the ripple uv displacement block
// no dependencies
package ruv_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_PHASE   = 3'd4;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;

    // sine polynomial, q30
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598669;
    localparam logic [30:0] SIN_C5 = 31'd85569305;
    localparam logic [30:0] SIN_C7 = 31'd5026994;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] Q30_POINT3 = 31'd322122547;

    typedef struct packed {
        logic [30:0] x;
        logic [30:0] x2;
        logic        neg;
    } sin_t;

    // horner coefficient for step k, highest order first
    function automatic logic [30:0] poly_coef(input logic [1:0] k);
        logic [30:0] c;
        case (k)
            2'd0:    c = SIN_C7;
            2'd1:    c = SIN_C5;
            2'd2:    c = SIN_C3;
            default: c = SIN_C1;
        endcase
        return c;
    endfunction

endpackage

/* design/ruv_div_cell.sv */
// one restoring division step, registered, for several lanes sharing a divisor
// no dependencies
module ruv_div_cell #(
    parameter int LANES  = 2,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             valid_i,
    input  logic [LANES-1:0][DEN_W-1:0]      rem_i,
    input  logic [LANES-1:0][NUM_W-1:0]      nq_i,
    input  logic [DEN_W-1:0]                 den_i,
    input  logic [SIDE_W-1:0]                side_i,
    output logic                             valid_o,
    output logic [LANES-1:0][DEN_W-1:0]      rem_o,
    output logic [LANES-1:0][NUM_W-1:0]      nq_o,
    output logic [DEN_W-1:0]                 den_o,
    output logic [SIDE_W-1:0]                side_o
);

    logic                        valid_reg;
    logic [LANES-1:0][DEN_W-1:0] rem_reg, rem_next;
    logic [LANES-1:0][NUM_W-1:0] nq_reg, nq_next;
    logic [DEN_W-1:0]            den_reg;
    logic [SIDE_W-1:0]           side_reg;

    always_comb
    begin
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        for (int l = 0; l < LANES; l++)
        begin
            shifted     = {rem_i[l], nq_i[l][NUM_W-1]};
            diff        = shifted - {1'b0, den_i};
            rem_next[l] = diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
            nq_next[l]  = {nq_i[l][NUM_W-2:0], ~diff[DEN_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            den_reg  <= den_i;
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign nq_o    = nq_reg;
    assign den_o   = den_reg;
    assign side_o  = side_reg;

endmodule

/* design/ruv_udiv.sv */
// pipelined unsigned divider, one quotient bit per cell
// depends on ruv_div_cell
module ruv_udiv #(
    parameter int LANES  = 2,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_i,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SIDE_W-1:0]           side_i,
    output logic                        valid_o,
    output logic [LANES-1:0][NUM_W-1:0] quo,
    output logic [SIDE_W-1:0]           side_o
);

    logic                        v_chain [0:NUM_W];
    logic [LANES-1:0][DEN_W-1:0] r_chain [0:NUM_W];
    logic [LANES-1:0][NUM_W-1:0] q_chain [0:NUM_W];
    logic [DEN_W-1:0]            d_chain [0:NUM_W];
    logic [SIDE_W-1:0]           s_chain [0:NUM_W];

    assign v_chain[0] = valid_i;
    assign r_chain[0] = '0;
    assign q_chain[0] = num;
    assign d_chain[0] = den;
    assign s_chain[0] = side_i;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        ruv_div_cell #(
            .LANES (LANES),
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .valid_i(v_chain[i]),
            .rem_i  (r_chain[i]),
            .nq_i   (q_chain[i]),
            .den_i  (d_chain[i]),
            .side_i (s_chain[i]),
            .valid_o(v_chain[i+1]),
            .rem_o  (r_chain[i+1]),
            .nq_o   (q_chain[i+1]),
            .den_o  (d_chain[i+1]),
            .side_o (s_chain[i+1])
        );
    end

    assign valid_o = v_chain[NUM_W];
    assign quo     = q_chain[NUM_W];
    assign side_o  = s_chain[NUM_W];

endmodule

/* design/ruv_sqrt_cell.sv */
// one digit-by-digit square root step, registered
// no dependencies
module ruv_sqrt_cell #(
    parameter int RW     = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_i,
    input  logic [RW+1:0]     rem_i,
    input  logic [RW-1:0]     root_i,
    input  logic [2*RW-1:0]   val_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output logic [RW+1:0]     rem_o,
    output logic [RW-1:0]     root_o,
    output logic [2*RW-1:0]   val_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              valid_reg;
    logic [RW+1:0]     rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [2*RW-1:0]   val_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;
        cur       = {rem_i, val_i[2*RW-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        diff      = cur - trial;
        ge        = (cur >= trial);
        rem_next  = ge ? diff[RW+1:0] : cur[RW+1:0];
        root_next = {root_i[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            val_reg  <= {val_i[2*RW-3:0], 2'b00};
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign val_o   = val_reg;
    assign side_o  = side_reg;

endmodule

/* design/ruv_isqrt.sv */
// pipelined integer square root, one root bit per cell
// depends on ruv_sqrt_cell
module ruv_isqrt #(
    parameter int RW     = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_i,
    input  logic [2*RW-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_o
);

    logic              v_chain [0:RW];
    logic [RW+1:0]     r_chain [0:RW];
    logic [RW-1:0]     q_chain [0:RW];
    logic [2*RW-1:0]   x_chain [0:RW];
    logic [SIDE_W-1:0] s_chain [0:RW];

    assign v_chain[0] = valid_i;
    assign r_chain[0] = '0;
    assign q_chain[0] = '0;
    assign x_chain[0] = radicand;
    assign s_chain[0] = side_i;

    for (genvar i = 0; i < RW; i++)
    begin : g_cell
        ruv_sqrt_cell #(
            .RW    (RW),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .valid_i(v_chain[i]),
            .rem_i  (r_chain[i]),
            .root_i (q_chain[i]),
            .val_i  (x_chain[i]),
            .side_i (s_chain[i]),
            .valid_o(v_chain[i+1]),
            .rem_o  (r_chain[i+1]),
            .root_o (q_chain[i+1]),
            .val_o  (x_chain[i+1]),
            .side_o (s_chain[i+1])
        );
    end

    assign valid_o = v_chain[RW];
    assign root    = q_chain[RW];
    assign side_o  = s_chain[RW];

endmodule

/* design/ripple_uv_displacement_top.sv */
// ripple uv displacement, top level
// depends on ruv_pkg, ruv_udiv, ruv_isqrt and the assertion macro header
//
// input stream: one pixel coordinate per transfer, output stream: one
// displaced texture coordinate per transfer, in the same order.
// registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while idle, since the block itself does not enforce it.
// the datapath is a row of registered cells: coordinate dividers, a square
// root, a pipelined sine polynomial, the length divider and the falloff
// divider, each divider giving one quotient bit per cell.
// throughput is one transfer per cycle while the receiver does not stall.
// when the receiver stalls the result waits in the output register while the
// pipeline keeps filling; input stalls only once a second result reaches the
// end of the row.
// reset clears all valid flags and loads the default frame size 1920x1080,
// origin zero and phase zero; no clearing pass is needed.
module ripple_uv_displacement_top
    import ruv_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pixel_x, pixel_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // sample_u, sample_v
    output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]          m_axis_tdata,
    input  logic                                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]                         cfg_addr,
    input  logic [CFG_DATA_W-1:0]                         cfg_wdata
);

    localparam int NW     = COORD_BITS + FRAC_BITS;
    localparam int A_W    = (NW > 31) ? 31 : NW;
    localparam int MAXSH  = NW - A_W;
    localparam int SH_W   = $clog2(MAXSH + 2);
    localparam int RW     = A_W + 1;
    localparam int LEN_W  = NW + 1;
    localparam int PROD_W = NW + FRAC_BITS;
    localparam int TN_W   = 2 * FRAC_BITS + 1;
    localparam int DN_W   = LEN_W + 4;
    localparam int OUT_W  = FRAC_BITS + 2;
    localparam int RES_W  = NW + 2;
    localparam int OUT_TW = ((2*OUT_W+7)/8)*8;
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((2**(OUT_W-1)) - 1);
    localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic             zero;
        logic [NW-1:0]    uvx;
        logic [NW-1:0]    uvy;
        logic [NW-1:0]    ax;
        logic [NW-1:0]    ay;
        logic             sx;
        logic             sy;
        logic [SH_W-1:0]  sh;
        logic [LEN_W-1:0] len;
        logic             wneg;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // configuration
    logic [12:0] fw_reg, fh_reg;
    logic [11:0] ox_reg, oy_reg;
    logic [15:0] phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= FRAME_WIDTH_RST;
            fh_reg    <= FRAME_HEIGHT_RST;
            ox_reg    <= '0;
            oy_reg    <= '0;
            phase_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  fw_reg    <= cfg_wdata[12:0];
                REG_FRAME_HEIGHT: fh_reg    <= cfg_wdata[12:0];
                REG_ORIGIN_X:     ox_reg    <= cfg_wdata[11:0];
                REG_ORIGIN_Y:     oy_reg    <= cfg_wdata[11:0];
                REG_TIME_PHASE:   phase_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // flow control
    logic                   adv;
    logic                   out_free;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_u_reg, out_v_reg;
    logic                   vd2;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign adv           = out_free || !vd2;
    assign s_axis_tready = adv;

    // coordinate dividers
    logic [12:0]                 fw_eff, fh_eff;
    logic [COORD_BITS-1:0]       pix_x, pix_y;
    logic [1:0][NW-1:0]          numx, numy, qx, qy;
    logic                        vx, vy;
    logic                        sidex, sidey;

    assign fw_eff = (fw_reg == '0) ? 13'd1 : fw_reg;
    assign fh_eff = (fh_reg == '0) ? 13'd1 : fh_reg;
    assign pix_x  = s_axis_tdata[COORD_BITS-1:0];
    assign pix_y  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign numx[0] = {pix_x, {FRAC_BITS{1'b0}}};
    assign numx[1] = {COORD_BITS'(ox_reg), {FRAC_BITS{1'b0}}};
    assign numy[0] = {pix_y, {FRAC_BITS{1'b0}}};
    assign numy[1] = {COORD_BITS'(oy_reg), {FRAC_BITS{1'b0}}};

    ruv_udiv #(.LANES(2), .NUM_W(NW), .DEN_W(13), .SIDE_W(1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(s_axis_tvalid),
        .num(numx), .den(fw_eff), .side_i(1'b0),
        .valid_o(vx), .quo(qx), .side_o(sidex)
    );

    ruv_udiv #(.LANES(2), .NUM_W(NW), .DEN_W(13), .SIDE_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(s_axis_tvalid),
        .num(numy), .den(fh_eff), .side_i(1'b0),
        .valid_o(vy), .quo(qy), .side_o(sidey)
    );

    // offset and magnitude
    logic  vb_reg;
    item_t itb_reg, itb_next;

    always_comb
    begin
        logic [NW:0] px;
        logic [NW:0] py;
        px = {1'b0, qx[0]} - {1'b0, qx[1]};
        py = {1'b0, qy[0]} - {1'b0, qy[1]};
        itb_next      = '0;
        itb_next.uvx  = qx[0];
        itb_next.uvy  = qy[0];
        itb_next.sx   = px[NW];
        itb_next.sy   = py[NW];
        itb_next.ax   = px[NW] ? NW'(-px) : px[NW-1:0];
        itb_next.ay   = py[NW] ? NW'(-py) : py[NW-1:0];
        itb_next.zero = sidex & sidey;
    end

    // scale down so the larger component fits A_W bits, at most 31
    logic           vc_reg;
    item_t          itc_reg, itc_next;
    logic [A_W-1:0] a_reg, b_reg, a_next, b_next;

    always_comb
    begin
        logic [NW-1:0]   m;
        logic [SH_W-1:0] sh;
        m  = (itb_reg.ax > itb_reg.ay) ? itb_reg.ax : itb_reg.ay;
        sh = '0;
        for (int s = MAXSH; s >= 0; s--)
        begin
            if ((m >> s) < ((NW+1)'(1) << A_W))
            begin
                sh = SH_W'(s);
            end
        end
        itc_next      = itb_reg;
        itc_next.zero = (m == '0);
        itc_next.sh   = sh;
        a_next        = A_W'(itb_reg.ax >> sh);
        b_next        = A_W'(itb_reg.ay >> sh);
    end

    // squares
    logic             vd_reg, ve_reg;
    item_t            itd_reg, ite_reg;
    logic [2*A_W-1:0] sqa_reg, sqb_reg;
    logic [2*RW-1:0]  sum_reg;

    // root
    logic          vq;
    item_t         itq;
    logic [RW-1:0] root;

    ruv_isqrt #(.RW(RW), .SIDE_W(ITEM_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(ve_reg),
        .radicand(sum_reg), .side_i(ite_reg),
        .valid_o(vq), .root(root), .side_o(itq)
    );

    // length and angle
    logic             vf_reg;
    item_t            itf_reg, itf_next;
    logic [15:0]      ang_reg, ang_next;

    always_comb
    begin
        logic [LEN_W+17:0] lsh;
        itf_next     = itq;
        itf_next.len = LEN_W'(root) << itq.sh;
        lsh          = {itf_next.len, 18'b0};
        ang_next     = lsh[FRAC_BITS+15:FRAC_BITS] + phase_reg;
    end

    // quadrant fold
    logic  vg_reg;
    item_t itg_reg;
    sin_t  sg_reg, sg_next;

    always_comb
    begin
        logic [14:0] r;
        logic [29:0] rr;
        r  = ang_reg[14] ? (15'd16384 - {1'b0, ang_reg[13:0]}) : {1'b0, ang_reg[13:0]};
        rr = r * r;
        sg_next.x   = {r, 16'b0};
        sg_next.x2  = {rr[28:0], 2'b00};
        sg_next.neg = ang_reg[15];
    end

    // horner steps
    logic        vs_reg   [0:3];
    item_t       its_reg  [0:3];
    sin_t        sn_reg   [0:3];
    logic [30:0] poly_reg [0:3];
    logic [30:0] poly_next[0:3];

    always_comb
    begin
        logic [61:0] prod;
        logic [30:0] mop;
        logic [30:0] x2;
        for (int k = 0; k < 4; k++)
        begin
            mop          = (k == 0) ? SIN_C9 : poly_reg[(k == 0) ? 0 : k-1];
            x2           = (k == 0) ? sg_reg.x2 : sn_reg[(k == 0) ? 0 : k-1].x2;
            prod         = x2 * mop;
            poly_next[k] = poly_coef(2'(k)) - prod[60:30];
        end
    end

    // sine, wave weight
    logic        vl_reg, vm_reg, vn_reg, vo_reg, vp_reg;
    item_t       itl_reg, itm_reg, itn_reg, ito_reg, itp_reg;
    item_t       ito_next;
    logic [30:0] s_reg, s_next;
    logic        sneg_reg;
    logic signed [31:0] h_reg, h_next;
    logic [29:0] mag_reg, mm_reg, mag_next, mm_next;
    logic        hneg_reg;
    logic [FRAC_BITS-1:0] wm_reg, wm_next;
    logic [PROD_W-1:0]    prodx_reg, prody_reg;

    always_comb
    begin
        logic [61:0] prod;
        prod   = sn_reg[3].x * poly_reg[3];
        s_next = (prod[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : prod[60:30];
    end

    always_comb
    begin
        logic [31:0] sum;
        sum = sneg_reg ? ({1'b0, Q30_ONE} - {1'b0, s_reg})
                       : ({1'b0, Q30_ONE} + {1'b0, s_reg});
        h_next = $signed({1'b0, sum[31:1]}) - $signed({1'b0, Q30_POINT3});
    end

    always_comb
    begin
        logic [31:0] habs;
        logic [59:0] sq;
        habs     = h_reg[31] ? 32'(-h_reg) : 32'(h_reg);
        mag_next = habs[29:0];
        sq       = mag_next * mag_next;
        mm_next  = sq[59:30];
    end

    always_comb
    begin
        logic [59:0] cu;
        cu      = mm_reg * mag_reg;
        wm_next = cu[59 -: FRAC_BITS];
    end

    always_comb
    begin
        ito_next      = itn_reg;
        ito_next.wneg = hneg_reg;
    end

    // length divider
    logic                  vt;
    item_t                 itt;
    logic [1:0][PROD_W-1:0] tnum, tq;

    assign tnum[0] = prodx_reg;
    assign tnum[1] = prody_reg;

    ruv_udiv #(.LANES(2), .NUM_W(PROD_W), .DEN_W(LEN_W), .SIDE_W(ITEM_W)) u_div_t (
        .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(vp_reg),
        .num(tnum), .den(itp_reg.len), .side_i(itp_reg),
        .valid_o(vt), .quo(tq), .side_o(itt)
    );

    // falloff divider
    logic                 vr_reg;
    item_t                itr_reg;
    logic [1:0][TN_W-1:0] dnum_reg, dnum_next, dq;
    logic [DN_W-1:0]      dden_reg, dden_next;
    item_t                itd2;

    always_comb
    begin
        dnum_next[0] = {tq[0][FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        dnum_next[1] = {tq[1][FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        dden_next    = DN_W'(2**FRAC_BITS) + DN_W'(itt.len) * DN_W'(5);
    end

    ruv_udiv #(.LANES(2), .NUM_W(TN_W), .DEN_W(DN_W), .SIDE_W(ITEM_W)) u_div_d (
        .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(vr_reg),
        .num(dnum_reg), .den(dden_reg), .side_i(itr_reg),
        .valid_o(vd2), .quo(dq), .side_o(itd2)
    );

    // displacement and saturation
    logic [OUT_W-1:0] out_u_next, out_v_next;

    always_comb
    begin
        logic signed [RES_W-1:0] uvx;
        logic signed [RES_W-1:0] uvy;
        logic signed [RES_W-1:0] dx;
        logic signed [RES_W-1:0] dy;
        logic signed [RES_W-1:0] rx;
        logic signed [RES_W-1:0] ry;
        uvx = $signed({2'b00, itd2.uvx});
        uvy = $signed({2'b00, itd2.uvy});
        dx  = $signed(RES_W'(dq[0][FRAC_BITS:0]));
        dy  = $signed(RES_W'(dq[1][FRAC_BITS:0]));
        if (itd2.zero)
        begin
            rx = uvx;
            ry = uvy;
        end
        else
        begin
            rx = (itd2.sx ^ itd2.wneg) ? uvx + dx : uvx - dx;
            ry = (itd2.sy ^ itd2.wneg) ? uvy + dy : uvy - dy;
        end
        if (rx > SAT_HI)
            out_u_next = SAT_HI[OUT_W-1:0];
        else if (rx < SAT_LO)
            out_u_next = SAT_LO[OUT_W-1:0];
        else
            out_u_next = rx[OUT_W-1:0];
        if (ry > SAT_HI)
            out_v_next = SAT_HI[OUT_W-1:0];
        else if (ry < SAT_LO)
            out_v_next = SAT_LO[OUT_W-1:0];
        else
            out_v_next = ry[OUT_W-1:0];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                vs_reg[k] <= 1'b0;
            end
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
            vo_reg <= 1'b0;
            vp_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg <= vx;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= vq;
            vg_reg <= vf_reg;
            vs_reg[0] <= vg_reg;
            for (int k = 1; k < 4; k++)
            begin
                vs_reg[k] <= vs_reg[k-1];
            end
            vl_reg <= vs_reg[3];
            vm_reg <= vl_reg;
            vn_reg <= vm_reg;
            vo_reg <= vn_reg;
            vp_reg <= vo_reg;
            vr_reg <= vt;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itb_reg <= itb_next;
            itc_reg <= itc_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            itd_reg <= itc_reg;
            sqa_reg <= a_reg * a_reg;
            sqb_reg <= b_reg * b_reg;
            ite_reg <= itd_reg;
            sum_reg <= (2*RW)'(sqa_reg) + (2*RW)'(sqb_reg);
            itf_reg <= itf_next;
            ang_reg <= ang_next;
            itg_reg <= itf_reg;
            sg_reg  <= sg_next;
            its_reg[0]  <= itg_reg;
            sn_reg[0]   <= sg_reg;
            poly_reg[0] <= poly_next[0];
            for (int k = 1; k < 4; k++)
            begin
                its_reg[k]  <= its_reg[k-1];
                sn_reg[k]   <= sn_reg[k-1];
                poly_reg[k] <= poly_next[k];
            end
            itl_reg  <= its_reg[3];
            s_reg    <= s_next;
            sneg_reg <= sn_reg[3].neg;
            itm_reg  <= itl_reg;
            h_reg    <= h_next;
            itn_reg  <= itm_reg;
            mag_reg  <= mag_next;
            mm_reg   <= mm_next;
            hneg_reg <= h_reg[31];
            ito_reg  <= ito_next;
            wm_reg   <= wm_next;
            itp_reg   <= ito_reg;
            prodx_reg <= ito_reg.ax * wm_reg;
            prody_reg <= ito_reg.ay * wm_reg;
            itr_reg  <= itt;
            dnum_reg <= dnum_next;
            dden_reg <= dden_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= vd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_u_reg <= out_u_next;
            out_v_reg <= out_v_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({out_v_reg, out_u_reg});

    `include "ripple_uv_displacement_top_assert.svh"

    `RUV_ASSERT_IMPLIES(a_div_lockstep, 1'b1, vx == vy, "coordinate dividers out of step")
    `RUV_ASSERT_IMPLIES(a_len_nonzero, vp_reg && !itp_reg.zero, itp_reg.len != '0,
        "zero length reached the length divider")
    `RUV_ASSERT_NEXT(a_end_held, vd2 && out_valid_reg && !m_axis_tready, vd2,
        "finished result dropped while output stalled")

endmodule

/* tb/sv/tb_ripple_uv_displacement_top.sv */
// testbench for ripple_uv_displacement_top: streams pixel coordinates, predicts
// displaced texture coordinates in fixed point and checks them in order
// depends on ruv_pkg and the design sources
`timescale 1ns / 100ps

module tb_ripple_uv_displacement_top
    import ruv_pkg::*;
();

    localparam int CB = 12;
    localparam int FB = 16;
    localparam int LATENCY = 3 * CB + 6 * FB + 19;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [11:0] py;
        logic [11:0] px;
    } pixel_t;

    typedef struct packed {
        logic [17:0] v;
        logic [17:0] u;
    } sample_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [12:0] cur_width;
    logic [12:0] cur_height;
    logic [11:0] cur_ox;
    logic [11:0] cur_oy;
    logic [15:0] cur_phase;

    pixel_t  pixel_queue[$];
    sample_t sample_queue[$];
    int      mismatches;
    int      gap_left;
    int      stall_left;
    bit      hold_req;
    bit      hold_on;
    bit      drain_wait;

    ripple_uv_displacement_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint wave_sine(input logic [15:0] ang);
        logic [1:0]      quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned poly;
        longint unsigned s;
        quad = ang[15:14];
        r = ang[13:0];
        if (quad[0])
            r = 16384 - r;
        x = r << 16;
        x2 = (x * x) >> 30;
        poly = SIN_C7 - ((x2 * SIN_C9) >> 30);
        poly = SIN_C5 - ((x2 * poly) >> 30);
        poly = SIN_C3 - ((x2 * poly) >> 30);
        poly = SIN_C1 - ((x2 * poly) >> 30);
        s = (x * poly) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic logic [17:0] clamp_q2(input longint v);
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[17:0];
    endfunction

    function automatic sample_t displace(input pixel_t p);
        longint          fw, fh, uvx, uvy, dxp, dyp, h, w, denom, tx, ty, dx, dy;
        longint unsigned ax, ay, m, a, b, len, ang, mag, cube;
        int              sh;
        sample_t         res;
        fw = (cur_width == 0) ? 1 : cur_width;
        fh = (cur_height == 0) ? 1 : cur_height;
        uvx = (longint'(p.px) << FB) / fw;
        uvy = (longint'(p.py) << FB) / fh;
        dxp = uvx - (longint'(cur_ox) << FB) / fw;
        dyp = uvy - (longint'(cur_oy) << FB) / fh;
        ax = dxp < 0 ? -dxp : dxp;
        ay = dyp < 0 ? -dyp : dyp;
        m = ax > ay ? ax : ay;
        if (m == 0)
        begin
            res.u = clamp_q2(uvx);
            res.v = clamp_q2(uvy);
            return res;
        end
        sh = 0;
        while ((m >> sh) >= (64'd1 << 31))
            sh++;
        a = ax >> sh;
        b = ay >> sh;
        len = root64(a * a + b * b) << sh;
        ang = (((len << 18) >> FB) + cur_phase) & 16'hFFFF;
        h = ((wave_sine(ang[15:0]) + longint'(Q30_ONE)) / 2) - longint'(Q30_POINT3);
        mag = h < 0 ? -h : h;
        cube = (((mag * mag) >> 30) * mag) >> 30;
        w = longint'(cube >> (30 - FB));
        if (h < 0)
            w = -w;
        tx = (dxp * w) / longint'(len);
        ty = (dyp * w) / longint'(len);
        denom = (longint'(1) << FB) + 5 * longint'(len);
        dx = (tx * (longint'(1) << FB)) / denom;
        dy = (ty * (longint'(1) << FB)) / denom;
        res.u = clamp_q2(uvx - dx);
        res.v = clamp_q2(uvy - dy);
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
        end
        else if (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end
        else if (pixel_queue.size() > 0 && !drain_wait)
        begin
            s_axis_tdata  <= pixel_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            gap_left      <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // predictor runs on every accepted input transfer
    always @(posedge clk)
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sample_queue.push_back(displace(pixel_t'(s_axis_tdata)));

    // long receiver stall, counted here
    initial
    begin
        hold_on = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (800) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        sample_t got;
        sample_t exp_s;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[35:0];
                if (sample_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer u=%h v=%h", got.u, got.v);
                end
                else
                begin
                    exp_s = sample_queue.pop_front();
                    if (got.u !== exp_s.u || got.v !== exp_s.v)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected u=%h v=%h, got u=%h v=%h",
                                     exp_s.u, exp_s.v, got.u, got.v);
                    end
                end
            end
            if (hold_on)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else if (!m_axis_tready || m_axis_tvalid)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= $urandom_range(0, 14);
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        for (int k = 0; k < 2; k++)
        begin
            @(posedge clk);
            while (pixel_queue.size() > 0 || s_axis_tvalid || sample_queue.size() > 0)
                @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cur_width  = val[12:0];
            REG_FRAME_HEIGHT: cur_height = val[12:0];
            REG_ORIGIN_X:     cur_ox     = val[11:0];
            REG_ORIGIN_Y:     cur_oy     = val[11:0];
            REG_TIME_PHASE:   cur_phase  = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_frame(input int fw, input int fh, input int ox, input int oy,
                             input int ph);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_TIME_PHASE, ph);
    endtask

    task automatic push_pixel(input int x, input int y);
        pixel_t p;
        p.px = x[11:0];
        p.py = y[11:0];
        pixel_queue.push_back(p);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        mismatches = 0;
        hold_req = 1'b0;
        drain_wait = 1'b0;
        cur_width = FRAME_WIDTH_RST;
        cur_height = FRAME_HEIGHT_RST;
        cur_ox = 0;
        cur_oy = 0;
        cur_phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, corners, origin hit
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(4095, 0);
        push_pixel(0, 4095);
        push_pixel(960, 540);
        push_pixel(1, 1);
        wait_idle();
        set_frame(1, 1, 4095, 0, 65535);
        push_pixel(0, 4095);
        push_pixel(4095, 0);
        push_pixel(4095, 4095);
        push_pixel(2048, 1);
        wait_idle();
        // zero frame size, beyond range frame size, unknown register
        set_frame(0, 8191, 100, 100, 16384);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'h1234);
        push_pixel(100, 100);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(101, 99);
        wait_idle();
        set_frame(4096, 4096, 2048, 2048, 32768);
        push_pixel(2048, 2048);
        push_pixel(2049, 2048);
        push_pixel(0, 4095);
        push_pixel(4095, 2047);
        wait_idle();

        // random phases with different settings
        for (int ph = 0; ph < 6; ph++)
        begin
            int n_items;
            n_items = (ph == 2) ? 200 : 46;
            if (ph == 0)
                set_frame(1920, 1080, $urandom_range(0, 1919), $urandom_range(0, 1079),
                          $urandom_range(0, 65535));
            else if (ph == 1)
                set_frame(1, 1, 0, 4095, 0);
            else
                set_frame($urandom_range(0, 8191), $urandom_range(0, 8191),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 65535));
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_pixel(cur_ox + $urandom_range(0, 6) - 3,
                               cur_oy + $urandom_range(0, 6) - 3);
                else
                    push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                if (ph == 3 && i == 40)
                begin
                    while (pixel_queue.size() > 0)
                        @(posedge clk);
                    drain_wait = 1'b1;
                    @(posedge clk);
                    while (s_axis_tvalid || sample_queue.size() > 0)
                        @(posedge clk);
                    drain_wait = 1'b0;
                end
            end
            wait_idle();
        end
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ruv_pkg.sv
design/ruv_div_cell.sv
design/ruv_udiv.sv
design/ruv_sqrt_cell.sv
design/ruv_isqrt.sv
design/ripple_uv_displacement_top.sv
tb/sv/tb_ripple_uv_displacement_top.sv
